// ===== design/krdq_pkg.sv =====
// Shared types, constants and slot arithmetic for the keyed record deque.
// No dependencies; imported by keyed_record_deque.
`default_nettype none

package krdq_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int KEY_W  = 32;
    localparam int NAME_W = 64;
    localparam int REC_W  = KEY_W + NAME_W;
    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;
    localparam int CNT_OUT_W = 5;

    localparam int IN_FIELDS_W  = CMD_W + KEY_W + NAME_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = STAT_W + 1 + KEY_W + NAME_W + CNT_OUT_W + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_DELETE     = 3'd4,
        CMD_SEARCH     = 3'd5,
        CMD_CLEAR      = 3'd6
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_RD,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } t_state;

    // Physical slot of a logical position: front + pos, wrapped once.
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] front,
                                                 input logic [IDX_W-1:0] pos);
        logic [IDX_W:0] sum;
        sum = {1'b0, front} + {1'b0, pos};
        if (sum >= (IDX_W+1)'(DEPTH)) begin
            sum = sum - (IDX_W+1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/keyed_record_deque.sv =====
// Keyed record deque: ordered store of up to DEPTH key/name records with
// push/pop at both ends, key search and delete-by-key. Depends on krdq_pkg.
//
// s_axis takes one command item per handshake (command, key, name_tag);
// m_axis returns exactly one result item per command, in order: status,
// found, record involved, record count after the command, empty flag.
// Each command passes through the sequencer. Push, clear, the unused code,
// and pop, search or delete on an empty store finish in the execute state;
// pop adds one registered read of the store; search scans positions up to
// the match or the end; delete on a match then closes the gap behind it.
// The store has one write and one registered read port; the scan and the
// gap close move one entry per cycle.
// s_axis_tready is high only while the sequencer is idle, from the cycle
// after the result loads, so a new command is taken only once the result
// of the last one has loaded. A result
// waiting on a stalled receiver sits in the output register; the next
// command is accepted and holds at its end until that register frees up.
// Reset empties the store (count and front slot to zero) and drops any
// pending result; the record memory is not cleared, only held entries are read.
`default_nettype none

module keyed_record_deque import krdq_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // s_axis_tdata, low bit up: command[2:0], key[31:0], name_tag[63:0], pad
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // m_axis_tdata, low bit up: status[1:0], found, out_key[31:0],
    // out_name[63:0], record_count[4:0], is_empty, pad
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready
);

    // Sequencer and command registers
    t_state              r_state, n_state;
    logic [CMD_W-1:0]    r_cmd;
    logic [KEY_W-1:0]    r_key;
    logic [NAME_W-1:0]   r_tag;

    // Deque bookkeeping
    logic [IDX_W-1:0]    r_front, n_front;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [IDX_W-1:0]    r_pos, n_pos;

    // Result being built
    t_status             r_res_status, n_res_status;
    logic                r_res_found, n_res_found;
    logic [KEY_W-1:0]    r_res_key, n_res_key;
    logic [NAME_W-1:0]   r_res_name, n_res_name;

    // Output register
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    // Record store: one write port, one registered read port
    logic [REC_W-1:0]    r_mem [DEPTH];
    logic [REC_W-1:0]    r_rd_data;
    logic                w_we;
    logic [IDX_W-1:0]    w_waddr;
    logic [REC_W-1:0]    w_wdata;
    logic [IDX_W-1:0]    w_raddr;

    // Shared decision signals
    logic                w_accept;
    logic                w_full;
    logic                w_empty;
    logic                w_match;
    logic                w_more1;
    logic                w_more2;
    logic                w_out_free;
    logic [CNT_W:0]      w_pos_p1;
    logic [CNT_W:0]      w_pos_p2;
    logic [31:0]         w_cnt_ext;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_full        = (r_count == CNT_W'(DEPTH));
    assign w_empty       = (r_count == '0);
    assign w_match       = (r_rd_data[KEY_W-1:0] == r_key);
    assign w_pos_p1      = (CNT_W+1)'(r_pos) + (CNT_W+1)'(1);
    assign w_pos_p2      = (CNT_W+1)'(r_pos) + (CNT_W+1)'(2);
    // Another record follows the current position / the one after it
    assign w_more1       = (w_pos_p1 < {1'b0, r_count});
    assign w_more2       = (w_pos_p2 < {1'b0, r_count});
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_cnt_ext     = 32'(r_count);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_cmd)
                    CMD_POP_FRONT, CMD_POP_BACK: begin
                        n_state = w_empty ? S_DONE : S_POP_RD;
                    end
                    CMD_DELETE, CMD_SEARCH: begin
                        n_state = w_empty ? S_DONE : S_SCAN;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_POP_RD: begin
                n_state = S_DONE;
            end
            S_SCAN: begin
                if (w_match) begin
                    n_state = (r_cmd == CMD_DELETE && w_more1) ? S_SHIFT : S_DONE;
                end else if (!w_more1) begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                if (!w_more2) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath and memory port control
    always_comb begin
        n_front      = r_front;
        n_count      = r_count;
        n_pos        = r_pos;
        n_res_status = r_res_status;
        n_res_found  = r_res_found;
        n_res_key    = r_res_key;
        n_res_name   = r_res_name;
        w_we         = 1'b0;
        w_waddr      = r_front;
        w_wdata      = {r_tag, r_key};
        w_raddr      = r_front;
        case (r_state)
            S_EXEC: begin
                n_res_status = STAT_OK;
                n_res_found  = 1'b0;
                n_res_key    = '0;
                n_res_name   = '0;
                case (r_cmd)
                    CMD_PUSH_FRONT: begin
                        if (w_full) begin
                            n_res_status = STAT_FULL;
                        end else begin
                            n_front = (r_front == '0) ? IDX_W'(DEPTH - 1)
                                                      : r_front - IDX_W'(1);
                            w_we    = 1'b1;
                            w_waddr = n_front;
                            n_count = r_count + CNT_W'(1);
                        end
                    end
                    CMD_PUSH_BACK: begin
                        if (w_full) begin
                            n_res_status = STAT_FULL;
                        end else begin
                            w_we    = 1'b1;
                            w_waddr = slot_of(r_front, r_count[IDX_W-1:0]);
                            n_count = r_count + CNT_W'(1);
                        end
                    end
                    CMD_POP_FRONT: begin
                        if (w_empty) begin
                            n_res_status = STAT_EMPTY;
                        end else begin
                            w_raddr = r_front;
                            n_front = slot_of(r_front, IDX_W'(1));
                            n_count = r_count - CNT_W'(1);
                        end
                    end
                    CMD_POP_BACK: begin
                        if (w_empty) begin
                            n_res_status = STAT_EMPTY;
                        end else begin
                            w_raddr = slot_of(r_front, IDX_W'(r_count - CNT_W'(1)));
                            n_count = r_count - CNT_W'(1);
                        end
                    end
                    CMD_DELETE, CMD_SEARCH: begin
                        if (w_empty) begin
                            n_res_status = STAT_EMPTY;
                        end else begin
                            w_raddr = r_front;
                            n_pos   = '0;
                        end
                    end
                    CMD_CLEAR: begin
                        n_count = '0;
                        n_front = '0;
                    end
                    default: begin
                        // unused code: leave the store alone
                    end
                endcase
            end
            S_POP_RD: begin
                n_res_key  = r_rd_data[KEY_W-1:0];
                n_res_name = r_rd_data[REC_W-1:KEY_W];
            end
            S_SCAN: begin
                if (w_match) begin
                    n_res_found  = 1'b1;
                    n_res_key    = r_rd_data[KEY_W-1:0];
                    n_res_name   = r_rd_data[REC_W-1:KEY_W];
                    if (r_cmd == CMD_DELETE) begin
                        if (w_more1) begin
                            w_raddr = slot_of(r_front, w_pos_p1[IDX_W-1:0]);
                        end else begin
                            n_count = r_count - CNT_W'(1);
                        end
                    end
                end else if (w_more1) begin
                    w_raddr = slot_of(r_front, w_pos_p1[IDX_W-1:0]);
                    n_pos   = w_pos_p1[IDX_W-1:0];
                end else begin
                    n_res_status = STAT_NOT_FOUND;
                end
            end
            S_SHIFT: begin
                // Close the gap: move the record one position toward the front
                w_we    = 1'b1;
                w_waddr = slot_of(r_front, r_pos);
                w_wdata = r_rd_data;
                n_pos   = w_pos_p1[IDX_W-1:0];
                if (w_more2) begin
                    w_raddr = slot_of(r_front, w_pos_p2[IDX_W-1:0]);
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // Record store
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_mem[w_raddr];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= s_axis_tdata[CMD_W-1:0];
            r_key <= s_axis_tdata[CMD_W +: KEY_W];
            r_tag <= s_axis_tdata[CMD_W+KEY_W +: NAME_W];
        end
        r_pos        <= n_pos;
        r_res_status <= n_res_status;
        r_res_found  <= n_res_found;
        r_res_key    <= n_res_key;
        r_res_name   <= n_res_name;
        if (r_state == S_DONE && w_out_free) begin
            r_out_data <= OUT_TDATA_W'({w_empty, w_cnt_ext[CNT_OUT_W-1:0], r_res_name,
                                        r_res_key, r_res_found, r_res_status});
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Assertions
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("record count beyond depth");

    a_front_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_front <= IDX_W'(DEPTH - 1))
        else $error("front slot out of range");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_EXEC))
        else $error("accepted item did not start execution");

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_EXEC || r_state == S_SHIFT))
        else $error("store written outside push or gap close");

    a_shift_ports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && w_more2) |-> (w_raddr != w_waddr))
        else $error("gap close reads the slot it writes");

endmodule

`default_nettype wire

// ===== test/tb_keyed_record_deque.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for keyed_record_deque: a directed table followed by
// segments of random commands, all scored against an in-bench deque predictor.
// Depends on krdq_pkg and keyed_record_deque.

module tb_keyed_record_deque;
    import krdq_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;   // the one code the block ignores

    localparam logic [KEY_W-1:0]  KEY_MAX  = 32'h7FFF_FFFF;
    localparam logic [KEY_W-1:0]  KEY_MIN  = 32'h8000_0000;
    localparam logic [KEY_W-1:0]  KEY_NEG1 = 32'hFFFF_FFFF;
    localparam logic [NAME_W-1:0] TAG_ONES = {NAME_W{1'b1}};

    // Bit offsets inside m_axis_tdata, low bit up.
    localparam int OFS_FOUND = STAT_W;
    localparam int OFS_KEY   = OFS_FOUND + 1;
    localparam int OFS_NAME  = OFS_KEY + KEY_W;
    localparam int OFS_COUNT = OFS_NAME + NAME_W;
    localparam int OFS_EMPTY = OFS_COUNT + CNT_OUT_W;

    localparam int RANDOM_ITEMS = 900;
    localparam int QUIET_TAIL   = 120;           // segments that start in the last items run with no idling
    localparam int DRAIN_WAIT   = 2 * DEPTH + 8; // longest command plus margin
    localparam int STALL_LIMIT  = 4000;          // cycles with no handshake at all

    typedef struct {
        t_status               status;
        logic                  found;
        logic [KEY_W-1:0]      rec_key;
        logic [NAME_W-1:0]     rec_name;
        logic [CNT_OUT_W-1:0]  count;
        logic                  empty;
    } deque_result_t;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [KEY_W-1:0]  key;
        logic [NAME_W-1:0] tag;
        int                reps;    // repeat with key and tag stepped by one
        bit                typed;   // expectation typed in the row
        deque_result_t     want;
    } table_row_t;

    typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_t;

    // DUT connections; every input is known from time zero.
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    // s_axis_tdata, low bit up: command[2:0], key[31:0], name_tag[63:0], pad
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // m_axis_tdata, low bit up: status[1:0], found, out_key[31:0],
    // out_name[63:0], record_count[4:0], is_empty, pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;

    // Predictor state: circular record store, front slot and record count.
    logic [KEY_W-1:0]  slot_keys [DEPTH];
    logic [NAME_W-1:0] slot_names[DEPTH];
    int                front_slot = 0;
    int                held_records = 0;

    deque_result_t     pending_results[$];
    table_row_t        directed_rows[$];

    bit idling_on = 1'b1;
    int stall_left = 0;
    int idle_cycles = 0;
    int error_count = 0;
    int commands_sent = 0;
    int results_checked = 0;
    int full_refusals = 0;
    int empty_hits = 0;
    int key_hits = 0;
    int key_misses = 0;

    keyed_record_deque dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    always #6 i_clk = ~i_clk;

    // Apply one command to the predictor state and return the result it gives.
    function automatic deque_result_t apply_command(input logic [CMD_W-1:0]  cmd,
                                                    input logic [KEY_W-1:0]  key,
                                                    input logic [NAME_W-1:0] tag);
        deque_result_t r;
        int slot;
        int pos;
        int p;
        r.status   = STAT_OK;
        r.found    = 1'b0;
        r.rec_key  = '0;
        r.rec_name = '0;
        case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (held_records == DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    if (cmd == CMD_PUSH_FRONT) begin
                        front_slot = (front_slot + DEPTH - 1) % DEPTH;
                        slot = front_slot;
                    end else begin
                        slot = (front_slot + held_records) % DEPTH;
                    end
                    slot_keys[slot]  = key;
                    slot_names[slot] = tag;
                    held_records++;
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                if (held_records == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    slot = (cmd == CMD_POP_FRONT) ? front_slot
                                                  : (front_slot + held_records - 1) % DEPTH;
                    r.rec_key  = slot_keys[slot];
                    r.rec_name = slot_names[slot];
                    if (cmd == CMD_POP_FRONT) begin
                        front_slot = (front_slot + 1) % DEPTH;
                    end
                    held_records--;
                end
            end
            CMD_DELETE, CMD_SEARCH: begin
                if (held_records == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    // Scan from the back so the front-most match wins.
                    pos = held_records;
                    for (p = held_records - 1; p >= 0; p--) begin
                        if (slot_keys[(front_slot + p) % DEPTH] == key) begin
                            pos = p;
                        end
                    end
                    if (pos == held_records) begin
                        r.status = STAT_NOT_FOUND;
                    end else begin
                        slot = (front_slot + pos) % DEPTH;
                        r.found    = 1'b1;
                        r.rec_key  = slot_keys[slot];
                        r.rec_name = slot_names[slot];
                        if (cmd == CMD_DELETE) begin
                            // Close the gap: later records move one step toward the front.
                            for (p = pos; p + 1 < held_records; p++) begin
                                slot_keys[(front_slot + p) % DEPTH] =
                                    slot_keys[(front_slot + p + 1) % DEPTH];
                                slot_names[(front_slot + p) % DEPTH] =
                                    slot_names[(front_slot + p + 1) % DEPTH];
                            end
                            held_records--;
                        end
                    end
                end
            end
            CMD_CLEAR: begin
                held_records = 0;
                front_slot   = 0;
            end
            default: begin
            end
        endcase
        r.count = CNT_OUT_W'(held_records);
        r.empty = (held_records == 0);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        $display("%0t ns result %0d: %s got 0x%0h expected 0x%0h",
                 $realtime, results_checked, what, got, want);
    endtask

    // Score one result item against the oldest pending expectation.
    task automatic check_result(input logic [OUT_TDATA_W-1:0] d);
        deque_result_t want;
        if (pending_results.size() == 0) begin
            report_mismatch("unexpected result item, tdata", 64'(d), 64'd0);
        end else begin
            want = pending_results.pop_front();
            if (d[0 +: STAT_W] !== want.status)
                report_mismatch("status", 64'(d[0 +: STAT_W]), 64'(want.status));
            if (d[OFS_FOUND] !== want.found)
                report_mismatch("found", 64'(d[OFS_FOUND]), 64'(want.found));
            if (d[OFS_KEY +: KEY_W] !== want.rec_key)
                report_mismatch("out_key", 64'(d[OFS_KEY +: KEY_W]), 64'(want.rec_key));
            if (d[OFS_NAME +: NAME_W] !== want.rec_name)
                report_mismatch("out_name", d[OFS_NAME +: NAME_W], want.rec_name);
            if (d[OFS_COUNT +: CNT_OUT_W] !== want.count)
                report_mismatch("record_count", 64'(d[OFS_COUNT +: CNT_OUT_W]),
                                64'(want.count));
            if (d[OFS_EMPTY] !== want.empty)
                report_mismatch("is_empty", 64'(d[OFS_EMPTY]), 64'(want.empty));
        end
        results_checked++;
    endtask

    // Receiver side: drop tready in random stall bursts while idling is on.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 4) == 0) begin
            stall_left    <= $urandom_range(1, 6) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Output monitor and stall counter; values read here are the pre-edge ones.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (m_axis_tvalid && m_axis_tready)
                check_result(m_axis_tdata);
        end
    end

    // Watchdog: end the run when the handshakes stop for too long.
    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("timeout: no item moved for %0d cycles, %0d results still pending",
                 STALL_LIMIT, pending_results.size());
        $display("tb_keyed_record_deque: done, errors");
        $finish;
    end

    // Offer one command, hold it until accepted, then record what it should give.
    task automatic drive_command(input logic [CMD_W-1:0]  cmd,
                                 input logic [KEY_W-1:0]  key,
                                 input logic [NAME_W-1:0] tag,
                                 input bit                typed,
                                 input deque_result_t     want);
        deque_result_t r;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tdata  <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, tag, key, cmd};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        // Accepted at this edge: advance the predictor.
        r = apply_command(cmd, key, tag);
        pending_results.push_back(typed ? want : r);
        commands_sent++;
        if (r.status == STAT_FULL)  full_refusals++;
        if (r.status == STAT_EMPTY) empty_hits++;
        if (r.found)                key_hits++;
        if (r.status == STAT_NOT_FOUND) key_misses++;
    endtask

    task automatic table_row(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                             input logic [NAME_W-1:0] tag, input int reps, input bit typed,
                             input t_status st, input logic fnd, input logic [KEY_W-1:0] okey,
                             input logic [NAME_W-1:0] oname, input int cnt);
        table_row_t row;
        row.cmd  = cmd;
        row.key  = key;
        row.tag  = tag;
        row.reps = reps;
        row.typed = typed;
        row.want.status   = st;
        row.want.found    = fnd;
        row.want.rec_key  = okey;
        row.want.rec_name = oname;
        row.want.count    = CNT_OUT_W'(cnt);
        row.want.empty    = (cnt == 0);
        directed_rows.push_back(row);
    endtask

    // Random command weighted by the segment's mix.
    function automatic logic [CMD_W-1:0] pick_command(input mix_t mix);
        int r;
        int t_pb, t_pf, t_popf, t_popb, t_del, t_srch, t_bad;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  begin t_pb = 35; t_pf = 65; t_popf = 73; t_popb = 80;
                             t_del = 87; t_srch = 96; t_bad = 98; end
            MIX_DRAIN: begin t_pb = 12; t_pf = 24; t_popf = 44; t_popb = 64;
                             t_del = 82; t_srch = 96; t_bad = 98; end
            default:   begin t_pb = 22; t_pf = 44; t_popf = 56; t_popb = 68;
                             t_del = 80; t_srch = 94; t_bad = 97; end
        endcase
        if (r < t_pb)   return CMD_PUSH_BACK;
        if (r < t_pf)   return CMD_PUSH_FRONT;
        if (r < t_popf) return CMD_POP_FRONT;
        if (r < t_popb) return CMD_POP_BACK;
        if (r < t_del)  return CMD_DELETE;
        if (r < t_srch) return CMD_SEARCH;
        if (r < t_bad)  return CMD_UNUSED;
        return CMD_CLEAR;
    endfunction

    initial begin
        deque_result_t    no_want;
        logic [KEY_W-1:0] key_pool[6];
        logic [KEY_W-1:0] key;
        logic [CMD_W-1:0] cmd;
        mix_t             mix;
        int               seg_len;
        int               random_sent;
        int               i;

        no_want = '{STAT_OK, 1'b0, '0, '0, '0, 1'b0};

        // Directed table. Typed rows carry their result; the rest go to the predictor.
        //        command         key       tag            reps typed status         fnd key      name      cnt
        table_row(CMD_POP_FRONT,  '0,       '0,            1,   1, STAT_EMPTY,     0, '0,      '0,       0);
        table_row(CMD_POP_BACK,   KEY_NEG1, TAG_ONES,      1,   1, STAT_EMPTY,     0, '0,      '0,       0);
        table_row(CMD_DELETE,     KEY_MAX,  '0,            1,   1, STAT_EMPTY,     0, '0,      '0,       0);
        table_row(CMD_SEARCH,     KEY_MIN,  '0,            1,   1, STAT_EMPTY,     0, '0,      '0,       0);
        table_row(CMD_UNUSED,     KEY_NEG1, TAG_ONES,      1,   1, STAT_OK,        0, '0,      '0,       0);
        table_row(CMD_CLEAR,      '0,       '0,            1,   1, STAT_OK,        0, '0,      '0,       0);
        table_row(CMD_PUSH_BACK,  KEY_MAX,  TAG_ONES,      1,   1, STAT_OK,        0, '0,      '0,       1);
        table_row(CMD_PUSH_FRONT, KEY_MIN,  '0,            1,   1, STAT_OK,        0, '0,      '0,       2);
        // the match sits in the last held entry
        table_row(CMD_SEARCH,     KEY_MAX,  '0,            1,   1, STAT_OK,        1, KEY_MAX, TAG_ONES, 2);
        table_row(CMD_SEARCH,     KEY_NEG1, '0,            1,   1, STAT_NOT_FOUND, 0, '0,      '0,       2);
        table_row(CMD_DELETE,     '0,       '0,            1,   1, STAT_NOT_FOUND, 0, '0,      '0,       2);
        table_row(CMD_UNUSED,     '0,       '0,            1,   1, STAT_OK,        0, '0,      '0,       2);
        table_row(CMD_POP_BACK,   '0,       '0,            1,   1, STAT_OK,        0, KEY_MAX, TAG_ONES, 1);
        table_row(CMD_POP_FRONT,  '0,       '0,            1,   1, STAT_OK,        0, KEY_MIN, '0,       0);
        // fill to the brim; the front push wraps the front slot below zero
        table_row(CMD_PUSH_BACK,  32'd100,  64'hA5A5_0000, 14,  0, STAT_OK,        0, '0,      '0,       0);
        table_row(CMD_PUSH_FRONT, 32'd100,  64'h5A5A_FFFF, 1,   0, STAT_OK,        0, '0,      '0,       0);
        table_row(CMD_PUSH_FRONT, 32'd200,  64'h1234_5678, 1,   0, STAT_OK,        0, '0,      '0,       0);
        table_row(CMD_PUSH_BACK,  KEY_NEG1, TAG_ONES,      1,   1, STAT_FULL,      0, '0,      '0,       16);
        table_row(CMD_PUSH_FRONT, '0,       '0,            1,   1, STAT_FULL,      0, '0,      '0,       16);
        // key hits at the back, at a duplicate near the front, and at the front
        table_row(CMD_SEARCH,     32'd113,  '0,            1,   0, STAT_OK,        0, '0,      '0,       0);
        table_row(CMD_DELETE,     32'd100,  '0,            1,   0, STAT_OK,        0, '0,      '0,       0);
        table_row(CMD_DELETE,     32'd113,  '0,            1,   0, STAT_OK,        0, '0,      '0,       0);
        table_row(CMD_DELETE,     32'd200,  '0,            1,   0, STAT_OK,        0, '0,      '0,       0);
        table_row(CMD_SEARCH,     32'd100,  '0,            1,   0, STAT_OK,        0, '0,      '0,       0);
        table_row(CMD_POP_BACK,   '0,       '0,            2,   0, STAT_OK,        0, '0,      '0,       0);
        table_row(CMD_CLEAR,      '0,       '0,            1,   1, STAT_OK,        0, '0,      '0,       0);
        table_row(CMD_PUSH_FRONT, KEY_MIN,  TAG_ONES,      1,   1, STAT_OK,        0, '0,      '0,       1);

        // Hold reset, then release it once for good.
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            for (i = 0; i < directed_rows[r].reps; i++) begin
                drive_command(directed_rows[r].cmd, directed_rows[r].key + KEY_W'(i),
                              directed_rows[r].tag + NAME_W'(i), directed_rows[r].typed,
                              directed_rows[r].want);
            end
        end

        // Random segments: each has its own key pool and command mix, so pushes
        // and key lookups share keys and reach full, empty and wrapped states.
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            seg_len = $urandom_range(40, 80);
            mix = mix_t'($urandom_range(0, 2));
            idling_on = (random_sent < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            foreach (key_pool[k]) begin
                case ($urandom_range(0, 5))
                    0:       key_pool[k] = KEY_MIN;
                    1:       key_pool[k] = KEY_MAX;
                    default: key_pool[k] = $urandom;
                endcase
            end
            for (i = 0; i < seg_len && random_sent < RANDOM_ITEMS; i++) begin
                cmd = pick_command(mix);
                key = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, 5)] : $urandom;
                drive_command(cmd, key, {$urandom, $urandom}, 1'b0, no_want);
                random_sent++;
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain: wait for every result, then give the block time to show extras.
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("covered %0d commands, %0d results scored: %0d full refusals, %0d on empty,",
                 commands_sent, results_checked, full_refusals, empty_hits);
        $display("  %0d key hits and %0d key misses across search and delete",
                 key_hits, key_misses);
        if (error_count == 0) begin
            $display("tb_keyed_record_deque: done, clean");
        end else begin
            $display("tb_keyed_record_deque: done, errors");
        end
        $finish;
    end

endmodule
